// ===== sv/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, opcodes, status codes, beat types and pointer helpers for the
// circular-buffer deque.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Capacity of the circular store and the widths that follow from it.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths of the beats.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned OCC_W  = 5;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

  // Status codes.
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // Input and output beats.
  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [ST_W-1:0]          status;
    logic [OCC_W-1:0]         occupancy;
  } dq_out_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic start;   // Execute the operation on the input beat this cycle.
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } dq_stat_t;

  // Step a pointer forward by one with wrap-around.
  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Step a pointer back by one with wrap-around.
  function automatic ptr_t ptr_dec(ptr_t p);
    ptr_t r;
    if (p == '0) begin
      r = PTR_W'(DEPTH - 1);
    end else begin
      r = p - PTR_W'(1);
    end
    return r;
  endfunction

  // Add an offset below DEPTH to a pointer, modulo DEPTH.
  function automatic ptr_t ptr_add(ptr_t p, cnt_t c);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(p) + (CNT_W + 1)'(c);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return PTR_W'(s);
  endfunction

endpackage

// ===== sv/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Deque controller
// Two-state sequencer: waits for an input beat, starts the datapath, then
// holds the result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  dq_pkg::dq_stat_t stat_i,
  output dq_pkg::dq_cmd_t  cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_q, state_d;
  logic accept;

  // An input beat is taken only while no result is pending.
  assign accept = in_valid_i && (state_q == S_IDLE);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Full and empty only steer the datapath; the sequence is the same for all.
  logic unused_stat;
  assign unused_stat = stat_i.full ^ stat_i.empty;

  assign cmd_o.start = accept && (unused_stat || !unused_stat);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_HOLD);

endmodule

// ===== sv/dq_datapath.sv =====
// ----------------------------------------------------------------------------
// Deque datapath
// Circular element store with front pointer and element count, plus the
// result registers for one output beat.
// ----------------------------------------------------------------------------
module dq_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dq_pkg::dq_cmd_t  cmd_i,
  input  dq_pkg::dq_in_t   in_data_i,
  output dq_pkg::dq_stat_t stat_o,
  output dq_pkg::dq_out_t  out_data_o
);

  logic [dq_pkg::DATA_W-1:0] mem [dq_pkg::DEPTH];

  dq_pkg::ptr_t front_q, front_d;
  dq_pkg::cnt_t count_q, count_d;

  logic                      we, re;
  dq_pkg::ptr_t              waddr, raddr;
  logic [dq_pkg::DATA_W-1:0] rd_q;
  logic [dq_pkg::ST_W-1:0]   status_d, status_q;
  logic                      pop_ok_d, pop_ok_q;
  dq_pkg::cnt_t              occ_q;
  logic                      full, empty;

  assign full  = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign empty = (count_q == '0);

  assign stat_o.full  = full;
  assign stat_o.empty = empty;

  // Decode the operation into store accesses and pointer updates.
  always_comb begin
    we       = 1'b0;
    re       = 1'b0;
    waddr    = front_q;
    raddr    = front_q;
    front_d  = front_q;
    count_d  = count_q;
    status_d = dq_pkg::ST_DONE;
    pop_ok_d = 1'b0;
    case (in_data_i.opcode)
      dq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_d = dq_pkg::ST_FULL;
        end else begin
          we      = 1'b1;
          waddr   = dq_pkg::ptr_dec(front_q);
          front_d = dq_pkg::ptr_dec(front_q);
          count_d = count_q + dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_d = dq_pkg::ST_FULL;
        end else begin
          we      = 1'b1;
          waddr   = dq_pkg::ptr_add(front_q, count_q);
          count_d = count_q + dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_d = dq_pkg::ST_EMPTY;
        end else begin
          re       = 1'b1;
          pop_ok_d = 1'b1;
          raddr    = front_q;
          front_d  = dq_pkg::ptr_inc(front_q);
          count_d  = count_q - dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_d = dq_pkg::ST_EMPTY;
        end else begin
          re       = 1'b1;
          pop_ok_d = 1'b1;
          raddr    = dq_pkg::ptr_add(front_q, count_q - dq_pkg::CNT_W'(1));
          count_d  = count_q - dq_pkg::CNT_W'(1);
        end
      end
      default: status_d = dq_pkg::ST_DONE;
    endcase
  end

  // Element store: one write or one registered read per operation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start && we) begin
      mem[waddr] <= in_data_i.push_value;
    end
    if (cmd_i.start && re) begin
      rd_q <= mem[raddr];
    end
  end

  // Pointer and count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.start) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // Result registers for the pending output beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
      occ_q    <= count_d;
    end
  end

  assign out_data_o.pop_value = pop_ok_q ? signed'(rd_q) : '1;
  assign out_data_o.status    = status_q;
  assign out_data_o.occupancy = dq_pkg::OCC_W'(occ_q);

endmodule

// ===== sv/double_ended_queue_unit.sv =====
// A result beat is valid in the cycle after its input beat is taken.
// The controller takes no new beat while a result is held, so a stalled
// output holds off the input.
// The element store has one write port and one registered read port.
// Reset (rst_ni low, asynchronous) empties the queue; store contents are
// left as they were and are never read before being written.
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Fixed-capacity deque of signed 32-bit words with push and pop at both ends.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dq_pkg::dq_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output dq_pkg::dq_out_t out_data_o
);

  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::dq_stat_t stat;

  // Sequencer.
  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Store, pointers and result registers.
  dq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

`ifndef ASSERT_OFF
  // Every accepted beat produces a result beat in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted beat did not produce a result");

  // The input side is held off exactly while a result is pending.
  a_stall_tracks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == out_valid_o)
    else $error("input stall does not match pending result");

  // A refused pop or a refused push reports no popped value.
  a_no_value_on_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == dq_pkg::ST_EMPTY ||
                     out_data_o.status == dq_pkg::ST_FULL))
    |-> (out_data_o.pop_value == -32'sd1))
    else $error("refused operation returned a value");
`endif

endmodule

// ===== tb/double_ended_queue_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue unit testbench
// Drives push and pop beats at both ends of the deque, predicts every result
// with a circular-buffer model of its own, and checks each output beat field
// by field. Both sides idle and stall at random between runs without gaps.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;

  localparam int unsigned CLK_HALF = 4;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  dq_pkg::dq_in_t  in_data_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  dq_pkg::dq_out_t out_data_o;

  double_ended_queue_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Shadow copy of the deque contents and pointers.
  logic [dq_pkg::DATA_W-1:0] shadow_store [dq_pkg::DEPTH];
  int unsigned               shadow_front = 0;
  int unsigned               shadow_count = 0;

  // Results predicted for accepted beats, oldest first.
  dq_pkg::dq_out_t pending_results [$];

  // Idling controls, changed by the tests.
  int unsigned in_gap_pct = 0;
  int unsigned stall_pct  = 0;

  // Run statistics.
  int unsigned error_count    = 0;
  int unsigned beats_taken    = 0;
  int unsigned results_seen   = 0;
  int unsigned full_refusals  = 0;
  int unsigned empty_refusals = 0;
  int unsigned peak_occupancy = 0;

  // Apply one operation to the shadow deque and return the result it gives.
  function automatic dq_pkg::dq_out_t deque_apply(dq_pkg::dq_in_t beat);
    dq_pkg::dq_out_t res;
    int unsigned     slot;
    res.pop_value = '1;
    res.status    = dq_pkg::ST_DONE;
    case (beat.opcode)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
        if (shadow_count >= dq_pkg::DEPTH) begin
          res.status = dq_pkg::ST_FULL;
        end else if (beat.opcode == dq_pkg::OP_PUSH_FRONT) begin
          shadow_front = (shadow_front + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
          shadow_store[shadow_front] = beat.push_value;
          shadow_count++;
        end else begin
          slot = (shadow_front + shadow_count) % dq_pkg::DEPTH;
          shadow_store[slot] = beat.push_value;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          res.status = dq_pkg::ST_EMPTY;
        end else if (beat.opcode == dq_pkg::OP_POP_FRONT) begin
          res.pop_value = shadow_store[shadow_front];
          shadow_front  = (shadow_front + 1) % dq_pkg::DEPTH;
          shadow_count--;
        end else begin
          slot = (shadow_front + shadow_count - 1) % dq_pkg::DEPTH;
          res.pop_value = shadow_store[slot];
          shadow_count--;
        end
      end
    endcase
    res.occupancy = dq_pkg::OCC_W'(shadow_count);
    return res;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what,
                                 input logic [dq_pkg::DATA_W-1:0] got,
                                 input logic [dq_pkg::DATA_W-1:0] want);
    error_count++;
    $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Short gaps are common, long ones rare.
  function automatic int unsigned pick_gap();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(30, 8);
    end
    return $urandom_range(3, 1);
  endfunction

  // Output stall generator.
  always @(posedge clk_i) begin : stall_gen
    int unsigned stall_left;
    if (stall_left == 0 && $urandom_range(99) < stall_pct) begin
      stall_left = pick_gap();
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Predict on every accepted input beat and check every accepted output beat.
  always @(posedge clk_i) begin : result_check
    dq_pkg::dq_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = deque_apply(in_data_i);
        if (want.status == dq_pkg::ST_FULL) full_refusals++;
        if (want.status == dq_pkg::ST_EMPTY) empty_refusals++;
        if (shadow_count > peak_occupancy) peak_occupancy = shadow_count;
        pending_results.push_back(want);
        beats_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result beat", out_data_o.pop_value, '1);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.pop_value !== want.pop_value)
            report_mismatch("pop_value", out_data_o.pop_value, want.pop_value);
          if (out_data_o.status !== want.status)
            report_mismatch("status", dq_pkg::DATA_W'(out_data_o.status),
                            dq_pkg::DATA_W'(want.status));
          if (out_data_o.occupancy !== want.occupancy)
            report_mismatch("occupancy", dq_pkg::DATA_W'(out_data_o.occupancy),
                            dq_pkg::DATA_W'(want.occupancy));
        end
      end
    end
  end

  // Send one beat; valid stays high into the next beat unless a gap is drawn.
  task automatic send_beat(input logic [dq_pkg::OP_W-1:0] op,
                           input logic [dq_pkg::DATA_W-1:0] value);
    int unsigned gap;
    if ($urandom_range(99) < in_gap_pct) begin
      gap = pick_gap();
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    in_data_i.opcode     <= op;
    in_data_i.push_value <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Mostly random words, with the signed extremes mixed in.
  function automatic logic [dq_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Pops on the empty queue at both ends.
  task automatic test_empty_pops();
    send_beat(dq_pkg::OP_POP_FRONT, 32'h1234_5678);
    send_beat(dq_pkg::OP_POP_BACK, 32'hFFFF_FFFF);
  endtask

  // Fill to capacity from both ends; the first front push wraps the pointer.
  task automatic test_fill_to_capacity();
    send_beat(dq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    send_beat(dq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_beat(dq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
    send_beat(dq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
    for (int i = 0; i < dq_pkg::DEPTH - 4; i++) begin
      send_beat(i[0] ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT, $urandom);
    end
  endtask

  // Pushes at both ends are refused while full.
  task automatic test_full_refusals();
    send_beat(dq_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF);
    send_beat(dq_pkg::OP_PUSH_BACK, 32'h5555_AAAA);
  endtask

  // Pop a few from both ends of the full queue.
  task automatic test_partial_drain();
    send_beat(dq_pkg::OP_POP_FRONT, $urandom);
    send_beat(dq_pkg::OP_POP_BACK, $urandom);
    send_beat(dq_pkg::OP_POP_BACK, $urandom);
    send_beat(dq_pkg::OP_POP_FRONT, $urandom);
  endtask

  // Random traffic in bursts that lean toward filling, draining or holding.
  task automatic test_random_traffic(input int unsigned n_beats);
    int unsigned push_pct;
    int unsigned burst_left;
    logic [dq_pkg::OP_W-1:0] op;
    burst_left = 0;
    push_pct   = 50;
    for (int unsigned i = 0; i < n_beats; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 15);
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      burst_left--;
      if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
      end
      send_beat(op, pick_word());
    end
  endtask

  // Stop driving and let the remaining results drain. The first edge lets the
  // checker record the beat taken at the edge where the last send returned.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_gap_pct = 20;
    stall_pct  = 20;
    test_empty_pops();
    test_fill_to_capacity();
    test_full_refusals();
    test_partial_drain();

    // No idling on either side.
    in_gap_pct = 0;
    stall_pct  = 0;
    test_random_traffic(120);

    // Light idling on both sides.
    in_gap_pct = 15;
    stall_pct  = 15;
    test_random_traffic(150);

    // Heavy output back-pressure with a steady sender.
    in_gap_pct = 5;
    stall_pct  = 50;
    test_random_traffic(80);

    // Sparse sender with occasional stalls.
    in_gap_pct = 50;
    stall_pct  = 10;
    test_random_traffic(80);

    wait_for_drain();

    $display("Checked %0d results from %0d beats; peak occupancy %0d.",
             results_seen, beats_taken, peak_occupancy);
    $display("Refused pushes when full: %0d, refused pops when empty: %0d.",
             full_refusals, empty_refusals);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("double_ended_queue_unit test passed");
    end else begin
      $display("double_ended_queue_unit test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("double_ended_queue_unit test failed");
    $finish;
  end

endmodule
